FILE: design/msm_pkg.sv
package msm_pkg;

  // Fixed field widths of the reading and result beats
  localparam int SAMPLE_W  = 16;
  localparam int AVERAGE_W = 16;

  // Sequencer state codes
  localparam int          STATE_W     = 3;
  localparam logic [2:0]  S_IDLE      = 3'd0;
  localparam logic [2:0]  S_MEAN_GO   = 3'd1;
  localparam logic [2:0]  S_MEAN_WAIT = 3'd2;
  localparam logic [2:0]  S_RD        = 3'd3;
  localparam logic [2:0]  S_ACC       = 3'd4;
  localparam logic [2:0]  S_PICK_GO   = 3'd5;
  localparam logic [2:0]  S_PICK_WAIT = 3'd6;
  localparam logic [2:0]  S_DONE      = 3'd7;

  // Status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/msm_stream_if.sv
interface msm_in_if;
  import msm_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface msm_out_if;
  import msm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [AVERAGE_W-1:0] average;
  logic                 overflow;

  modport source (output valid, output average, output overflow, input ready);
  modport sink   (input valid, input average, input overflow, output ready);
endinterface

FILE: design/msm_ram.sv
module msm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: design/msm_div.sv
module msm_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output logic [NUM_W-1:0]    quo_o,
  output msm_pkg::div_stat_t  stat_o
);
  import msm_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W:0]    trial;
  logic              ge;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = STEP_W'(NUM_W);
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d  = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d  = {quo_q[NUM_W-2:0], ge};
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a run");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q != '0) && (step_q <= STEP_W'(NUM_W)))
    else $error("divider step count out of range");
`endif

endmodule

FILE: design/majority_side_mean_top.sv
// Readings: one beat per cycle is taken while a frame fills (ready high in idle).
// End of frame: after the last beat, a first divider run gives the frame mean;
// a pass over the kept readings in the reading RAM (read, then accumulate, per
// entry) sorts them by side, and a second divider run averages the winning side.
// A finished result waits in an output register while the next frame loads.
// Reset (async, active low) empties the frame and drops any pending result.
module majority_side_mean_top #(
  parameter int MAX_READINGS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msm_in_if.sink    in_i,
  msm_out_if.source out_o
);
  import msm_pkg::*;

  localparam int CW    = $clog2(MAX_READINGS + 1);
  localparam int AW    = (MAX_READINGS > 1) ? $clog2(MAX_READINGS) : 1;
  localparam int SUM_W = SAMPLE_W + CW;

  logic [STATE_W-1:0]   state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic                 dropped_q, dropped_d;
  logic [SAMPLE_W-1:0]  mean_q, mean_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [SUM_W-1:0]     up_sum_q, up_sum_d, lo_sum_q, lo_sum_d;
  logic [CW-1:0]        up_n_q, up_n_d, lo_n_q, lo_n_d;
  logic                 out_valid_q, out_valid_d;
  logic [AVERAGE_W-1:0] out_avg_q, out_avg_d;
  logic                 out_ovf_q, out_ovf_d;

  logic                 accept;
  logic                 has_room;
  logic                 ram_we;
  logic                 ram_re;
  logic [SAMPLE_W-1:0]  ram_rdata;
  logic                 div_start;
  logic [SUM_W-1:0]     div_num;
  logic [CW-1:0]        div_den;
  logic [SUM_W-1:0]     div_quo;
  div_stat_t            div_stat;
  logic                 sel_up;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign has_room   = (count_q < CW'(MAX_READINGS));
  assign ram_we     = accept && has_room;
  assign ram_re     = (state_q == S_RD);
  assign sel_up     = (up_n_q >= lo_n_q);

  // Divider operands: frame mean first, then the winning side
  always_comb begin
    if (state_q == S_MEAN_GO) begin
      div_num = sum_q;
      div_den = count_q;
    end else begin
      div_num = sel_up ? up_sum_q : lo_sum_q;
      div_den = sel_up ? up_n_q : lo_n_q;
    end
  end
  assign div_start = (state_q == S_MEAN_GO) || (state_q == S_PICK_GO);

  msm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_READINGS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_i.sample),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  msm_div #(
    .NUM_W (SUM_W),
    .DEN_W (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    dropped_d   = dropped_q;
    mean_d      = mean_q;
    idx_d       = idx_q;
    up_sum_d    = up_sum_q;
    lo_sum_d    = lo_sum_q;
    up_n_d      = up_n_q;
    lo_n_d      = lo_n_q;
    out_valid_d = out_valid_q;
    out_avg_d   = out_avg_q;
    out_ovf_d   = out_ovf_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (has_room) begin
            count_d = count_q + 1'b1;
            sum_d   = sum_q + SUM_W'(in_i.sample);
          end else begin
            dropped_d = 1'b1;
          end
          if (in_i.last) begin
            state_d = S_MEAN_GO;
          end
        end
      end
      S_MEAN_GO: begin
        up_sum_d = '0;
        lo_sum_d = '0;
        up_n_d   = '0;
        lo_n_d   = '0;
        idx_d    = '0;
        state_d  = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (div_stat.done) begin
          mean_d  = div_quo[SAMPLE_W-1:0];
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (ram_rdata >= mean_q) begin
          up_sum_d = up_sum_q + SUM_W'(ram_rdata);
          up_n_d   = up_n_q + 1'b1;
        end else begin
          lo_sum_d = lo_sum_q + SUM_W'(ram_rdata);
          lo_n_d   = lo_n_q + 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = ((idx_q + 1'b1) == count_q) ? S_PICK_GO : S_RD;
      end
      S_PICK_GO: begin
        state_d = S_PICK_WAIT;
      end
      S_PICK_WAIT: begin
        if (div_stat.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Load the result once the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_avg_d   = div_quo[AVERAGE_W-1:0];
          out_ovf_d   = dropped_q;
          count_d     = '0;
          sum_d       = '0;
          dropped_d   = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sum_q       <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q    <= mean_d;
    idx_q     <= idx_d;
    up_sum_q  <= up_sum_d;
    lo_sum_q  <= lo_sum_d;
    up_n_q    <= up_n_d;
    lo_n_q    <= lo_n_d;
    out_avg_q <= out_avg_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.average  = out_avg_q;
  assign out_o.overflow = out_ovf_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_READINGS))
    else $error("reading count beyond capacity");
  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped_q |-> (count_q == CW'(MAX_READINGS)))
    else $error("drop flag set with room left");
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RD) || (state_q == S_ACC)) |-> (idx_q < count_q))
    else $error("scan index past kept readings");
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(out_valid_q) && out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside the done state");
`endif

endmodule
